### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the step sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define SRMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define SRMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/srms_pkg.sv
// ---------------------------------------------------------------------------
// srms_pkg
// Types and constants for the step sequencer run-mode stepper.
// ---------------------------------------------------------------------------
package srms_pkg;

	localparam int RandW   = 32;
	localparam int CountW  = 7;
	localparam int HistW   = 16;
	localparam int PosOutW = 6;
	localparam int DivSteps = RandW;

	// config register indexes
	localparam logic CFG_STEP_COUNT = 1'b0;
	localparam logic CFG_RUN_MODE   = 1'b1;

	// run modes
	localparam logic [3:0] MODE_FORWARD    = 4'd0;
	localparam logic [3:0] MODE_REVERSE    = 4'd1;
	localparam logic [3:0] MODE_PINGPONG   = 4'd2;
	localparam logic [3:0] MODE_PENDULUM   = 4'd3;
	localparam logic [3:0] MODE_BROWNIAN   = 4'd4;
	localparam logic [3:0] MODE_RANDOM     = 4'd5;
	localparam logic [3:0] MODE_RANDOM2    = 4'd6;
	localparam logic [3:0] MODE_FORWARD_X2 = 4'd7;
	localparam logic [3:0] MODE_FORWARD_X3 = 4'd8;
	localparam logic [3:0] MODE_FORWARD_X4 = 4'd9;

	// history bands, one per mode family
	localparam logic [HistW-1:0] BASE_FWD  = 16'h1000;
	localparam logic [HistW-1:0] BASE_REV  = 16'h2000;
	localparam logic [HistW-1:0] BASE_PP   = 16'h3000;
	localparam logic [HistW-1:0] BASE_PEND = 16'h4000;
	localparam logic [HistW-1:0] BASE_BROW = 16'h5000;
	localparam logic [HistW-1:0] BASE_RAND = 16'h6000;
	localparam logic [HistW-1:0] BAND_SPAN = 16'h0FFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} srms_state_t;

	typedef struct packed {
		logic              start;
		logic [RandW-1:0]  dividend;
		logic [CountW-1:0] divisor;
	} srms_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [CountW-1:0] remainder;
	} srms_div_stat_t;

	function automatic logic band_stale(logic [HistW-1:0] h, logic [HistW-1:0] base);
		return (h < base + 16'd1) || (h > base + BAND_SPAN);
	endfunction

endpackage

### design/srms_mod_unit.sv
// ---------------------------------------------------------------------------
// srms_mod_unit
// Bit-serial restoring remainder: 32-bit dividend mod 7-bit divisor,
// one dividend bit per cycle.
// ---------------------------------------------------------------------------
module srms_mod_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srms_pkg::srms_div_req_t req,
	output srms_pkg::srms_div_stat_t stat
);

	localparam int CntW = $clog2(srms_pkg::DivSteps + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CntW-1:0]               cnt_q;
	logic [srms_pkg::RandW-1:0]    dvd_q;
	logic [srms_pkg::CountW-1:0]   dvs_q;
	logic [srms_pkg::CountW-1:0]   rem_q;
	logic [srms_pkg::CountW:0]     trial;
	logic [srms_pkg::CountW-1:0]   rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[srms_pkg::RandW-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = srms_pkg::CountW'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[srms_pkg::CountW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(srms_pkg::DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[srms_pkg::RandW-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy      = busy_q;
	assign stat.done      = done_q;
	assign stat.remainder = rem_q;

endmodule

### design/sequencer_run_mode_stepper.sv
// ---------------------------------------------------------------------------
// sequencer_run_mode_stepper
// Step-sequencer position advancer with pass detection for all run modes.
// ---------------------------------------------------------------------------
// Flow: forward, reverse, ping-pong and pendulum ticks go from idle to the
//   finish state and on to the output register; brownian and random ticks
//   first wait in the calc state for the bit-serial remainder unit (32 steps,
//   one dividend bit per cycle). One tick at a time, taken the cycle after
//   commit; a stall on the output holds off the commit.
// Reset (arst_n low, async): step count 16, forward mode, position 0,
//   history 0, no result pending.
module sequencer_run_mode_stepper #(
	parameter int MAX_STEPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	// tick transaction in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] random_word,
	// result transaction out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  position,
	output logic        pass_done
);

	`include "assert_macros.svh"

	// Step count never exceeds the 7-bit register, so the cap is the smaller.
	localparam int CapSteps = (MAX_STEPS > 127) ? 127 : MAX_STEPS;
	localparam logic [srms_pkg::CountW-1:0] CAP_W = srms_pkg::CountW'(CapSteps);

	localparam int SW = srms_pkg::CountW + 2;  // signed working width

	// config registers
	logic [srms_pkg::CountW-1:0] step_count_q;
	logic [3:0]                  run_mode_q;

	// sequencer state
	logic [srms_pkg::CountW-1:0] pos_q;
	logic [srms_pkg::HistW-1:0]  hist_q;
	logic [srms_pkg::RandW-1:0]  rnd_q;

	// output register
	logic                        out_valid_q;
	logic [srms_pkg::PosOutW-1:0] out_pos_q;
	logic                        out_done_q;

	srms_pkg::srms_state_t       state_q, state_d;
	srms_pkg::srms_div_req_t     div_req;
	srms_pkg::srms_div_stat_t    div_stat;

	logic [srms_pkg::CountW-1:0] nu;
	logic                        needs_div;
	logic                        commit;
	logic                        in_fire;

	// next-tick results
	logic signed [SW-1:0]        p;
	logic signed [SW-1:0]        n_s;
	logic [srms_pkg::HistW-1:0]  h;
	logic                        done;
	logic [srms_pkg::HistW-1:0]  fwd_base;

	// effective step count: zero reads as 1, large values saturate
	always_comb begin
		if (step_count_q == '0) begin
			nu = srms_pkg::CountW'(1);
		end else if (step_count_q > CAP_W) begin
			nu = CAP_W;
		end else begin
			nu = step_count_q;
		end
	end

	assign needs_div = (run_mode_q == srms_pkg::MODE_BROWNIAN) ||
		(run_mode_q == srms_pkg::MODE_RANDOM) || (run_mode_q == srms_pkg::MODE_RANDOM2);

	assign in_ready = (state_q == srms_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign commit   = (state_q == srms_pkg::ST_FINISH) && (!out_valid_q || out_ready);

	// remainder request: brownian needs mod 3, random needs mod step count
	always_comb begin
		div_req.start    = in_fire && needs_div;
		div_req.dividend = random_word;
		if (run_mode_q == srms_pkg::MODE_BROWNIAN) begin
			div_req.divisor = srms_pkg::CountW'(3);
		end else begin
			div_req.divisor = nu;
		end
	end

	srms_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// FSM next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srms_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = needs_div ? srms_pkg::ST_CALC : srms_pkg::ST_FINISH;
				end
			end
			srms_pkg::ST_CALC: begin
				if (div_stat.done) begin
					state_d = srms_pkg::ST_FINISH;
				end
			end
			srms_pkg::ST_FINISH: begin
				if (commit) begin
					state_d = srms_pkg::ST_IDLE;
				end
			end
			default: state_d = srms_pkg::ST_IDLE;
		endcase
	end

	// position / history update; one pass of this logic per tick
	always_comb begin
		p        = SW'(signed'({2'b00, pos_q}));
		n_s      = SW'(signed'({2'b00, nu}));
		h        = hist_q;
		done     = 1'b0;
		fwd_base = srms_pkg::BASE_FWD + 16'd1;
		unique case (run_mode_q)
			srms_pkg::MODE_REVERSE: begin
				if (srms_pkg::band_stale(h, srms_pkg::BASE_REV)) h = srms_pkg::BASE_REV + 16'd1;
				p = p - SW'(1);
				if (p < 0) begin
					p    = n_s - SW'(1);
					h    = h - 16'd1;
					done = (h <= srms_pkg::BASE_REV);
				end
			end
			srms_pkg::MODE_PINGPONG: begin
				if (srms_pkg::band_stale(h, srms_pkg::BASE_PP)) h = srms_pkg::BASE_PP + 16'd2;
				if (!h[0]) begin
					// forward leg: the end step repeats on the turn
					p = p + SW'(1);
					if (p >= n_s) begin
						p = n_s - SW'(1);
						h = h - 16'd1;
					end
				end else begin
					p = p - SW'(1);
					if (p < 0) begin
						p    = '0;
						h    = h - 16'd1;
						done = (h <= srms_pkg::BASE_PP);
					end
				end
			end
			srms_pkg::MODE_PENDULUM: begin
				if (srms_pkg::band_stale(h, srms_pkg::BASE_PEND)) h = srms_pkg::BASE_PEND + 16'd2;
				if (!h[0]) begin
					p = p + SW'(1);
					if (p >= n_s) begin
						p = n_s - SW'(2);
						h = h - 16'd1;
						// one or two steps: the turn is also the pass end
						if (p < SW'(1)) begin
							p    = '0;
							h    = h - 16'd1;
							done = (h <= srms_pkg::BASE_PEND);
						end
					end
				end else begin
					p = p - SW'(1);
					if (p < SW'(1)) begin
						p    = '0;
						h    = h - 16'd1;
						done = (h <= srms_pkg::BASE_PEND);
					end
				end
			end
			srms_pkg::MODE_BROWNIAN: begin
				if (srms_pkg::band_stale(h, srms_pkg::BASE_BROW)) begin
					h = srms_pkg::BASE_BROW + {9'd0, nu};
				end
				p = p + SW'(signed'({1'b0, div_stat.remainder})) - SW'(1);
				if (p >= n_s) p = '0;
				if (p < 0) p = n_s - SW'(1);
				h    = h - 16'd1;
				done = (h <= srms_pkg::BASE_BROW);
			end
			srms_pkg::MODE_RANDOM, srms_pkg::MODE_RANDOM2: begin
				if (srms_pkg::band_stale(h, srms_pkg::BASE_RAND)) begin
					h = srms_pkg::BASE_RAND + {9'd0, nu};
				end
				p    = SW'(signed'({2'b00, div_stat.remainder}));
				h    = h - 16'd1;
				done = (h <= srms_pkg::BASE_RAND);
			end
			default: begin
				// forward; modes fw2..fw4 arm more repetitions
				if (run_mode_q == srms_pkg::MODE_FORWARD_X2) begin
					fwd_base = srms_pkg::BASE_FWD + 16'd2;
				end else if (run_mode_q == srms_pkg::MODE_FORWARD_X3) begin
					fwd_base = srms_pkg::BASE_FWD + 16'd3;
				end else if (run_mode_q == srms_pkg::MODE_FORWARD_X4) begin
					fwd_base = srms_pkg::BASE_FWD + 16'd4;
				end
				if (srms_pkg::band_stale(h, srms_pkg::BASE_FWD)) h = fwd_base;
				p = p + SW'(1);
				if (p >= n_s) begin
					p    = '0;
					h    = h - 16'd1;
					done = (h <= srms_pkg::BASE_FWD);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= srms_pkg::CountW'(16);
			run_mode_q   <= srms_pkg::MODE_FORWARD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srms_pkg::CFG_STEP_COUNT: step_count_q <= cfg_data;
				srms_pkg::CFG_RUN_MODE:   run_mode_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				pos_q       <= p[srms_pkg::CountW-1:0];
				hist_q      <= h;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rnd_q <= random_word;
		end
		if (commit) begin
			out_pos_q  <= p[srms_pkg::PosOutW-1:0];
			out_done_q <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = out_pos_q;
	assign pass_done = out_done_q;

	// Assertions
	`SRMS_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_stat.busy && !div_stat.done,
		"divider active while accepting a tick")
	`SRMS_ASSERT_NOW(a_done_in_calc, div_stat.done, state_q == srms_pkg::ST_CALC,
		"remainder finished outside the calc state")
	`SRMS_ASSERT_NEXT(a_tick_blocks, in_valid && in_ready, !in_ready,
		"tick accepted back to back")
	`SRMS_ASSERT_NEXT(a_rnd_held, state_q == srms_pkg::ST_CALC, $stable(rnd_q),
		"captured random word changed mid-tick")

endmodule

### test/tb_sequencer_run_mode_stepper.sv
// ---------------------------------------------------------------------------
// tb_sequencer_run_mode_stepper
// Self-checking bench for the run-mode step advancer.
// ---------------------------------------------------------------------------
// Each tick transaction goes through an in-bench model of the position and
// pass-history logic. The block's results are checked field by field, in
// order, against the model. The run has three parts. A short directed part
// covers every run mode but fw2 and fw3, an unused mode code, zero and
// oversized step counts, corner random words, and a stale position after
// the count drops. A pressure part holds the result side off long enough
// to stall the input. A long random part uses random register settings
// and random words, with random idle cycles on both sides.
// ---------------------------------------------------------------------------
module tb_sequencer_run_mode_stepper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxSteps = 64;
	localparam int RandomTicks = 720;
	localparam int HoldCycles = 250;
	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 40;      // slack for a tick in the slow brownian and random modes
	localparam logic [3:0] MODE_SPARE_LAST = 4'd15;   // unused code, acts as forward

	typedef struct packed {
		logic [5:0] pos;
		logic       done;
	} step_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = srms_pkg::CFG_STEP_COUNT;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] random_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  position;
	logic        pass_done;

	// model copies of the registers and state
	logic [6:0]  steps_reg = 7'd16;
	logic [3:0]  mode_reg = srms_pkg::MODE_FORWARD;
	int          cur_pos = 0;
	logic [15:0] pass_hist = '0;

	logic [31:0]  tick_q[$];      // ticks waiting to be offered
	step_result_t due_steps[$];   // expected results, oldest first

	bit tx_calm = 1'b0;           // no sender gaps in this phase
	bit rx_calm = 1'b0;           // no receiver stalls in this phase
	bit hold_armed = 1'b0;
	logic rx_hold = 1'b0;         // long receiver hold-off
	int tx_wait = 0;
	int rx_wait = 0;

	int cycles = 0;
	int ticks_taken = 0;
	int results_seen = 0;
	int passes_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int corner_idx = 0;

	const logic [31:0] corner_words[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

	sequencer_run_mode_stepper #(.MAX_STEPS(MaxSteps)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.random_word(random_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.pass_done  (pass_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Position model
	// ---------------------------------------------------------------------

	// History outside the active mode's band means the pass count re-arms.
	function automatic bit hist_stale(input logic [15:0] base);
		return (pass_hist <= base) || (pass_hist > base + srms_pkg::BAND_SPAN);
	endfunction

	// One step of the pass count; the pass ends once it hits the band base.
	function automatic logic pass_tick(input logic [15:0] base);
		pass_hist = pass_hist - 16'd1;
		return pass_hist <= base;
	endfunction

	function automatic step_result_t advance_step(input logic [31:0] rnd);
		step_result_t res;
		logic [31:0] nu;
		int n;
		int p;
		int reps;
		logic done;
		// zero count acts as one, oversized counts saturate
		nu = (steps_reg == 7'd0) ? 32'd1 : 32'(steps_reg);
		if (nu > MaxSteps)
			nu = MaxSteps;
		n = int'(nu);
		p = cur_pos;
		done = 1'b0;
		case (mode_reg)
			srms_pkg::MODE_REVERSE: begin
				if (hist_stale(srms_pkg::BASE_REV))
					pass_hist = srms_pkg::BASE_REV + 16'd1;
				p--;
				if (p < 0) begin
					p = n - 1;
					done = pass_tick(srms_pkg::BASE_REV);
				end
			end
			srms_pkg::MODE_PINGPONG: begin
				// even history: rising leg, odd: falling leg
				if (hist_stale(srms_pkg::BASE_PP))
					pass_hist = srms_pkg::BASE_PP + 16'd2;
				if (!pass_hist[0]) begin
					p++;
					if (p >= n) begin
						p = n - 1;
						pass_hist = pass_hist - 16'd1;
					end
				end else begin
					p--;
					if (p < 0) begin
						p = 0;
						done = pass_tick(srms_pkg::BASE_PP);
					end
				end
			end
			srms_pkg::MODE_PENDULUM: begin
				// like ping-pong but the end steps play once
				if (hist_stale(srms_pkg::BASE_PEND))
					pass_hist = srms_pkg::BASE_PEND + 16'd2;
				if (!pass_hist[0]) begin
					p++;
					if (p >= n) begin
						p = n - 2;
						pass_hist = pass_hist - 16'd1;
						if (p < 1) begin
							p = 0;
							done = pass_tick(srms_pkg::BASE_PEND);
						end
					end
				end else begin
					p--;
					if (p < 1) begin
						p = 0;
						done = pass_tick(srms_pkg::BASE_PEND);
					end
				end
			end
			srms_pkg::MODE_BROWNIAN: begin
				if (hist_stale(srms_pkg::BASE_BROW))
					pass_hist = srms_pkg::BASE_BROW + 16'(nu);
				p = p + int'(rnd % 32'd3) - 1;
				if (p >= n)
					p = 0;
				if (p < 0)
					p = n - 1;
				done = pass_tick(srms_pkg::BASE_BROW);
			end
			srms_pkg::MODE_RANDOM, srms_pkg::MODE_RANDOM2: begin
				if (hist_stale(srms_pkg::BASE_RAND))
					pass_hist = srms_pkg::BASE_RAND + 16'(nu);
				p = int'(rnd % nu);
				done = pass_tick(srms_pkg::BASE_RAND);
			end
			default: begin
				// forward, repeated passes for the fw2..fw4 codes
				reps = 1;
				if (mode_reg == srms_pkg::MODE_FORWARD_X2)
					reps = 2;
				else if (mode_reg == srms_pkg::MODE_FORWARD_X3)
					reps = 3;
				else if (mode_reg == srms_pkg::MODE_FORWARD_X4)
					reps = 4;
				if (hist_stale(srms_pkg::BASE_FWD))
					pass_hist = srms_pkg::BASE_FWD + 16'(reps);
				p++;
				if (p >= n) begin
					p = 0;
					done = pass_tick(srms_pkg::BASE_FWD);
				end
			end
		endcase
		cur_pos = p;
		res.pos = 6'(p);
		res.done = done;
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
	endtask

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Small counts dominate so passes complete often.
	function automatic logic [6:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 7'($urandom_range(1, 8));
		if (r < 85)
			return 7'($urandom_range(9, 64));
		if ($urandom_range(0, 2) == 0)
			return 7'd0;
		return 7'($urandom_range(64, 127));
	endfunction

	// Mode code in the low nibble, junk in the bits above it.
	function automatic logic [6:0] pick_mode_word();
		logic [3:0] m;
		if ($urandom_range(0, 99) < 85)
			m = 4'($urandom_range(0, 9));
		else
			m = 4'($urandom_range(10, 15));
		return {3'($urandom_range(0, 7)), m};
	endfunction

	task automatic queue_ticks(input int n, input int corner_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < corner_pct) begin
				tick_q.push_back(corner_words[corner_idx % 8]);
				corner_idx++;
			end else begin
				tick_q.push_back($urandom());
			end
		end
	endtask

	// Wait until every tick is taken and every result is back.
	task automatic drain();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_valid || due_steps.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Registers only change while the block is idle.
	task automatic set_regs(input logic [6:0] cnt, input logic [6:0] mode_word);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= srms_pkg::CFG_STEP_COUNT;
		cfg_data <= cnt;
		@(posedge clk);
		cfg_index <= srms_pkg::CFG_RUN_MODE;
		cfg_data <= mode_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		steps_reg = cnt;
		mode_reg = mode_word[3:0];
		settings_used++;
	endtask

	// ---------------------------------------------------------------------
	// Tick driver: offers queued ticks, models each accepted transaction
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		step_result_t r;
		int g;
		if (!arst_n) begin
			in_valid <= 1'b0;
			random_word <= '0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				r = advance_step(random_word);
				due_steps.push_back(r);
				ticks_taken++;
			end
			// slot is free when nothing is offered or the offer just went through
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					random_word <= tick_q.pop_front();
					in_valid <= 1'b1;
					g = tx_calm ? 0 : pick_gap();
					tx_wait <= g;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result side: random stalls plus the long hold-off
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= 1'b0;
		end else begin
			// stall after a transaction or now and then out of the blue
			g = 0;
			if (!rx_calm && ((out_valid && out_ready) || $urandom_range(0, 15) == 0))
				g = pick_gap();
			if (g > 0) begin
				rx_wait <= g - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !rx_hold;
			end
		end
	end

	// Long hold-off, counted here; the sender keeps offering meanwhile.
	initial begin
		wait (hold_armed);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (due_steps.size() == 0) begin
				report_mismatch("result with no tick pending, position", position, 0);
			end else begin
				want = due_steps.pop_front();
				if (position !== want.pos)
					report_mismatch("position", position, want.pos);
				if (pass_done !== want.done)
					report_mismatch("pass_done", pass_done, want.done);
				if (want.done)
					passes_seen++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, due_steps.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		int random_sent;
		int n;
		random_sent = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: reset settings first, then every mode but fw2 and fw3 with corner counts.
		queue_ticks(2, 100);
		drain();
		set_regs(7'd1, {3'b000, srms_pkg::MODE_FORWARD});     // single step: pass every tick
		queue_ticks(2, 100);
		drain();
		set_regs(7'd0, {3'b000, srms_pkg::MODE_REVERSE});     // zero count acts as one
		queue_ticks(2, 100);
		drain();
		set_regs(7'd2, {3'b000, srms_pkg::MODE_PENDULUM});    // pendulum with no inner steps
		queue_ticks(3, 100);
		drain();
		set_regs(7'd127, {3'b000, srms_pkg::MODE_BROWNIAN});  // count saturates
		queue_ticks(3, 100);
		drain();
		set_regs(7'd64, {3'b000, srms_pkg::MODE_RANDOM});     // low-ones word hits top step
		queue_ticks(3, 100);
		drain();
		set_regs(7'd3, {3'b000, srms_pkg::MODE_PINGPONG});    // stale high position turns
		queue_ticks(3, 100);
		drain();
		set_regs(7'd5, {3'b000, srms_pkg::MODE_RANDOM2});
		queue_ticks(2, 100);
		drain();
		set_regs(7'd3, {3'b101, srms_pkg::MODE_FORWARD_X4});  // upper data bits ignored
		queue_ticks(2, 100);
		drain();
		set_regs(7'd65, {3'b111, MODE_SPARE_LAST});           // unused code runs forward
		queue_ticks(2, 100);

		// Pressure: hold results off while ticks keep coming.
		drain();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		set_regs(7'd8, {3'b000, srms_pkg::MODE_FORWARD_X3});
		queue_ticks(40, 0);
		hold_armed = 1'b1;

		// Random phases, each with its own settings and idling.
		while (random_sent < RandomTicks) begin
			drain();
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			set_regs(pick_count(), pick_mode_word());
			n = $urandom_range(15, 60);
			queue_ticks(n, 8);
			random_sent += n;
		end

		drain();
		repeat (DrainCycles) @(posedge clk);
		if (due_steps.size() != 0)
			report_mismatch("results never delivered, count", 0, due_steps.size());

		$display("Ran %0d ticks under %0d register settings, %0d results checked.",
			ticks_taken, settings_used, results_seen);
		$display("Saw %0d completed passes; %0d mismatches.", passes_seen, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
